// ----- design/trie_word_prefix_counter_unit_defines.svh -----
// assertion macros for the checker file
`ifndef TRIE_WORD_PREFIX_COUNTER_UNIT_DEFINES_SVH
`define TRIE_WORD_PREFIX_COUNTER_UNIT_DEFINES_SVH

// consequent checked at the same edge
`define TWPC_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent checked at the next edge
`define TWPC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- design/twpc_pkg.sv -----
`default_nettype none
package twpc_pkg;

	localparam int NODES      = 256;
	localparam int ALPHABET   = 26;
	localparam int COUNT_BITS = 16;

	localparam int NODE_BITS   = $clog2(NODES);
	localparam int FREE_BITS   = $clog2(NODES + 1);
	localparam int SLOT_DEPTH  = NODES * ALPHABET;
	localparam int SLOT_BITS   = $clog2(SLOT_DEPTH);
	localparam int MODE_BITS   = 2;
	localparam int LETTER_BITS = 5;
	localparam int OUT_BITS    = 16;
	localparam int OUT_MAX     = (1 << OUT_BITS) - 1;
	localparam int CLIP_BITS   = (COUNT_BITS > OUT_BITS) ? COUNT_BITS : OUT_BITS;

	localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

	localparam logic [MODE_BITS-1:0] MODE_INSERT = 2'd0;
	localparam logic [MODE_BITS-1:0] MODE_WORD   = 2'd1;
	localparam logic [MODE_BITS-1:0] MODE_PREFIX = 2'd2;
	localparam logic [MODE_BITS-1:0] MODE_NONE   = 2'd3;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_ROOT,
		S_ROOT_WR,
		S_STEP,
		S_CHILD,
		S_PFX_WR,
		S_END,
		S_FIN,
		S_OUT
	} twpc_state_t;

	typedef struct packed {
		logic clr_step;
		logic load;
		logic miss_set;
		logic ovf_set;
		logic child_rd;
		logic advance;
		logic alloc;
		logic cnt_rd;
		logic cnt_rd_child;
		logic pfx_wr;
		logic fin_miss;
		logic fin_hit;
		logic emit;
	} twpc_cmd_t;

	typedef struct packed {
		logic clr_done;
		logic in_word;
		logic miss;
		logic empty;
		logic ends;
		logic insert;
		logic letter_bad;
		logic child_zero;
		logic pool_out;
		logic slot_free;
	} twpc_stat_t;

	function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
		return (v == CNT_MAX) ? v : v + COUNT_BITS'(1);
	endfunction

	function automatic logic [OUT_BITS-1:0] clip_out(input logic [COUNT_BITS-1:0] v);
		logic [CLIP_BITS-1:0] w;
		w = CLIP_BITS'(v);
		if (w > CLIP_BITS'(OUT_MAX)) begin
			return OUT_BITS'(OUT_MAX);
		end
		return OUT_BITS'(w);
	endfunction

endpackage
`default_nettype wire

// ----- design/twpc_ram.sv -----
`default_nettype none
module twpc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

// ----- design/twpc_ctrl.sv -----
`default_nettype none
module twpc_ctrl import twpc_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic [MODE_BITS-1:0] mode,
	output logic                 in_stall,
	input  twpc_stat_t           stat,
	output twpc_cmd_t            cmd
);

	twpc_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_stall = 1'b1;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (stat.clr_done) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				in_stall = 1'b0;
				if (in_valid && mode != MODE_NONE) begin
					cmd.load = 1'b1;
					// a new word that inserts bumps the root first
					if (mode == MODE_INSERT && !stat.in_word) begin
						state_d = S_ROOT;
					end else begin
						state_d = S_STEP;
					end
				end
			end
			S_ROOT: begin
				cmd.cnt_rd = 1'b1;
				state_d    = S_ROOT_WR;
			end
			S_ROOT_WR: begin
				cmd.pfx_wr = 1'b1;
				state_d    = S_STEP;
			end
			S_STEP: begin
				if (stat.empty || stat.miss) begin
					state_d = S_END;
				end else if (stat.letter_bad) begin
					cmd.miss_set = 1'b1;
					state_d      = S_END;
				end else begin
					cmd.child_rd = 1'b1;
					state_d      = S_CHILD;
				end
			end
			S_CHILD: begin
				if (stat.child_zero && !stat.insert) begin
					cmd.miss_set = 1'b1;
					state_d      = S_END;
				end else if (stat.child_zero && stat.pool_out) begin
					cmd.miss_set = 1'b1;
					cmd.ovf_set  = 1'b1;
					state_d      = S_END;
				end else begin
					cmd.advance = 1'b1;
					cmd.alloc   = stat.child_zero;
					if (stat.insert) begin
						cmd.cnt_rd       = 1'b1;
						cmd.cnt_rd_child = 1'b1;
						state_d          = S_PFX_WR;
					end else begin
						state_d = S_END;
					end
				end
			end
			S_PFX_WR: begin
				cmd.pfx_wr = 1'b1;
				state_d    = S_END;
			end
			S_END: begin
				if (!stat.ends) begin
					state_d = S_IDLE;
				end else if (stat.miss) begin
					cmd.fin_miss = 1'b1;
					state_d      = S_OUT;
				end else begin
					cmd.cnt_rd = 1'b1;
					state_d    = S_FIN;
				end
			end
			S_FIN: begin
				cmd.fin_hit = 1'b1;
				state_d     = S_OUT;
			end
			S_OUT: begin
				if (stat.slot_free) begin
					cmd.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule
`default_nettype wire

// ----- design/twpc_dp.sv -----
`default_nettype none
module twpc_dp import twpc_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  twpc_cmd_t              cmd,
	output twpc_stat_t             stat,
	input  logic [MODE_BITS-1:0]   mode,
	input  logic [LETTER_BITS-1:0] letter,
	input  logic                   last,
	input  logic                   empty_req,
	input  logic                   out_stall,
	output logic                   out_valid,
	output logic [OUT_BITS-1:0]    count,
	output logic                   has_word,
	output logic                   pool_full
);

	logic [MODE_BITS-1:0]   mode_q;
	logic [LETTER_BITS-1:0] letter_q;
	logic                   last_q;
	logic                   empty_q;

	logic [NODE_BITS-1:0] cur_q;
	logic [FREE_BITS-1:0] next_free_q;
	logic                 in_word_q;
	logic                 miss_q;
	logic                 ovf_q;
	logic [SLOT_BITS-1:0] clr_q;
	logic                 out_valid_q;

	logic [OUT_BITS-1:0] res_cnt_q;
	logic                res_has_q;
	logic                res_full_q;
	logic [OUT_BITS-1:0] count_q;
	logic                has_word_q;
	logic                pool_full_q;

	logic [SLOT_BITS-1:0]    slot;
	logic [NODE_BITS-1:0]    child_rdata;
	logic                    child_we;
	logic [SLOT_BITS-1:0]    child_waddr;
	logic [NODE_BITS-1:0]    child_wdata;
	logic [NODE_BITS-1:0]    new_child;
	logic                    child_zero;
	logic                    insert;
	logic                    clr_cnt;

	logic [2*COUNT_BITS-1:0] cnt_rdata;
	logic [2*COUNT_BITS-1:0] cnt_wdata;
	logic                    cnt_we;
	logic [NODE_BITS-1:0]    cnt_waddr;
	logic [NODE_BITS-1:0]    cnt_raddr;
	logic [COUNT_BITS-1:0]   rd_word;
	logic [COUNT_BITS-1:0]   rd_pfx;
	logic [COUNT_BITS-1:0]   word_new;

	assign insert     = (mode_q == MODE_INSERT);
	assign slot       = SLOT_BITS'(cur_q) * SLOT_BITS'(ALPHABET) + SLOT_BITS'(letter_q);
	assign child_zero = (child_rdata == '0);
	assign new_child  = child_zero ? next_free_q[NODE_BITS-1:0] : child_rdata;
	assign clr_cnt    = cmd.clr_step && (int'(clr_q) < NODES);

	assign child_we    = cmd.clr_step || cmd.alloc;
	assign child_waddr = cmd.clr_step ? clr_q : slot;
	assign child_wdata = cmd.clr_step ? '0 : next_free_q[NODE_BITS-1:0];

	twpc_ram #(
		.WIDTH(NODE_BITS),
		.DEPTH(SLOT_DEPTH)
	) u_child_ram (
		.clk   (clk),
		.we    (child_we),
		.waddr (child_waddr),
		.wdata (child_wdata),
		.re    (cmd.child_rd),
		.raddr (slot),
		.rdata (child_rdata)
	);

	// count memory row is {word count, prefix count}
	assign rd_word  = cnt_rdata[2*COUNT_BITS-1:COUNT_BITS];
	assign rd_pfx   = cnt_rdata[COUNT_BITS-1:0];
	assign word_new = insert ? sat_inc(rd_word) : rd_word;

	assign cnt_we    = clr_cnt || cmd.pfx_wr || (cmd.fin_hit && insert);
	assign cnt_waddr = cmd.clr_step ? clr_q[NODE_BITS-1:0] : cur_q;
	assign cnt_raddr = cmd.cnt_rd_child ? new_child : cur_q;

	always_comb begin
		if (cmd.clr_step) begin
			cnt_wdata = '0;
		end else if (cmd.pfx_wr) begin
			cnt_wdata = {rd_word, sat_inc(rd_pfx)};
		end else begin
			cnt_wdata = {word_new, rd_pfx};
		end
	end

	twpc_ram #(
		.WIDTH(2 * COUNT_BITS),
		.DEPTH(NODES)
	) u_cnt_ram (
		.clk   (clk),
		.we    (cnt_we),
		.waddr (cnt_waddr),
		.wdata (cnt_wdata),
		.re    (cmd.cnt_rd),
		.raddr (cnt_raddr),
		.rdata (cnt_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q       <= '0;
			next_free_q <= FREE_BITS'(1);
			in_word_q   <= 1'b0;
			miss_q      <= 1'b0;
			ovf_q       <= 1'b0;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.clr_step) begin
				clr_q <= clr_q + SLOT_BITS'(1);
			end
			// first request of a word restarts at the root
			if (cmd.load && !in_word_q) begin
				cur_q     <= '0;
				miss_q    <= 1'b0;
				ovf_q     <= 1'b0;
				in_word_q <= 1'b1;
			end
			if (cmd.miss_set) begin
				miss_q <= 1'b1;
			end
			if (cmd.ovf_set) begin
				ovf_q <= 1'b1;
			end
			if (cmd.advance) begin
				cur_q <= new_child;
			end
			if (cmd.alloc) begin
				next_free_q <= next_free_q + FREE_BITS'(1);
			end
			if (cmd.fin_miss || cmd.fin_hit) begin
				cur_q     <= '0;
				miss_q    <= 1'b0;
				ovf_q     <= 1'b0;
				in_word_q <= 1'b0;
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q   <= mode;
			letter_q <= letter;
			last_q   <= last;
			empty_q  <= empty_req;
		end
		if (cmd.fin_miss) begin
			res_cnt_q  <= '0;
			res_has_q  <= 1'b0;
			res_full_q <= insert && ovf_q;
		end
		if (cmd.fin_hit) begin
			res_cnt_q  <= (mode_q == MODE_PREFIX) ? clip_out(rd_pfx) : clip_out(word_new);
			res_has_q  <= (word_new != '0);
			res_full_q <= insert && ovf_q;
		end
		if (cmd.emit) begin
			count_q     <= res_cnt_q;
			has_word_q  <= res_has_q;
			pool_full_q <= res_full_q;
		end
	end

	assign stat.clr_done   = (clr_q == SLOT_BITS'(SLOT_DEPTH - 1));
	assign stat.in_word    = in_word_q;
	assign stat.miss       = miss_q;
	assign stat.empty      = empty_q;
	assign stat.ends       = empty_q || last_q;
	assign stat.insert     = insert;
	assign stat.letter_bad = (int'(letter_q) >= ALPHABET);
	assign stat.child_zero = child_zero;
	assign stat.pool_out   = (next_free_q >= FREE_BITS'(NODES));
	assign stat.slot_free  = !out_valid_q || !out_stall;

	assign out_valid = out_valid_q;
	assign count     = count_q;
	assign has_word  = has_word_q;
	assign pool_full = pool_full_q;

endmodule
`default_nettype wire

// ----- design/trie_word_prefix_counter_unit.sv -----
// per letter: IDLE, STEP, CHILD, PFX_WR, END for an insert, IDLE, STEP, CHILD, END for a
// lookup, IDLE, STEP, END once the path is missing or for an empty request; the first
// insert request of a word adds ROOT and ROOT_WR; the request that ends a word adds FIN
// (not on a missing path) and OUT before its result sits in the output register, plus any
// wait while the previous result is still stalled; one request in flight at a time; a held
// result does not block the next request; after reset the child table is swept once, stall high
`default_nettype none
module trie_word_prefix_counter_unit import twpc_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [MODE_BITS-1:0]   mode,
	input  logic [LETTER_BITS-1:0] letter,
	input  logic                   last,
	input  logic                   empty_req,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [OUT_BITS-1:0]    count,
	output logic                   has_word,
	output logic                   pool_full
);

	twpc_cmd_t  cmd;
	twpc_stat_t stat;

	twpc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.mode     (mode),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	twpc_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.mode      (mode),
		.letter    (letter),
		.last      (last),
		.empty_req (empty_req),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.count     (count),
		.has_word  (has_word),
		.pool_full (pool_full)
	);

endmodule
`default_nettype wire

// ----- design/twpc_checker.sv -----
`default_nettype none
`include "trie_word_prefix_counter_unit_defines.svh"
module twpc_checker import twpc_pkg::*; (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 in_valid,
	input logic                 in_stall,
	input logic [MODE_BITS-1:0] mode,
	input logic                 out_valid,
	input logic                 out_stall,
	input logic [OUT_BITS-1:0]  count,
	input logic                 has_word,
	input logic                 pool_full
);

	// one request at a time
	`TWPC_ASSERT_NEXT(a_busy_after_req, in_valid && !in_stall && mode != MODE_NONE, in_stall, "request taken while busy")

	// a result needs at least the walk step after its request
	`TWPC_ASSERT_NEXT(a_no_early_result, in_valid && !in_stall && mode != MODE_NONE, !$rose(out_valid), "result too soon after request")

	// an overflowed insert never reports a word
	`TWPC_ASSERT_SAME(a_full_is_empty, out_valid && pool_full, count == '0 && !has_word, "pool full result carries a count")

	`TWPC_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(count) && $stable(has_word) && $stable(pool_full), "stalled result changed")

endmodule

bind trie_word_prefix_counter_unit twpc_checker u_twpc_checker (.*);
`default_nettype wire
